/* design/umcd_pkg.sv */
package umcd_pkg;

  // command codes reported with each finished line
  typedef enum logic [2:0] {
    CMD_UNKNOWN = 3'd0,
    CMD_FORWARD = 3'd1,
    CMD_BACK    = 3'd2,
    CMD_RIGHT   = 3'd3,
    CMD_LEFT    = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_SPEED   = 3'd6
  } cmd_t;

  // number parser phase
  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  localparam int unsigned HEAD_COUNT    = 5;
  localparam int unsigned NUMBER_START  = 3;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned SPEED_W       = 10;
  localparam int unsigned ACC_W         = 14;
  localparam int unsigned DUTY_W        = 18;
  localparam int unsigned SPEED_MAX     = 999;
  localparam int unsigned DUTY_FULL     = 20000;
  localparam int unsigned PERCENT_SCALE = 100;
  localparam int unsigned DUTY_SCALE    = DUTY_FULL / PERCENT_SCALE;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0] TAB_CODE     = 8'd9;
  localparam logic [CHAR_W-1:0] CR_CODE      = 8'd13;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] DIGIT_NINE   = 8'd57;

  // pin level patterns: bit0 a_fwd, bit1 a_rev, bit2 b_fwd, bit3 b_rev
  localparam logic [3:0] PINS_FORWARD = 4'b0101;
  localparam logic [3:0] PINS_BACK    = 4'b1010;
  localparam logic [3:0] PINS_OFF     = 4'b0000;

endpackage

/* design/uart_motor_command_decoder_top.sv */
// Motor command line decoder. Each accepted in_rx_byte is one received UART character; a
// newline (10) closes the line and produces exactly one result transfer, any other byte
// produces none. The first five characters of a line are matched against ileri, geri, sag,
// sol, dur and hiz (first match wins; anything else reports command 0 and changes nothing).
// For hiz, a decimal number starting at character 3 (leading whitespace skipped, saturating
// at 999, a sign or other leading character giving 0) sets both duties to n*200. sag and
// sol halve duty one or duty two. Characters from position LINE_LENGTH-1 on are dropped
// until the newline. Each byte passes through the input register and is then decoded into
// the state and result registers. One byte is taken per cycle; the only backpressure comes
// from a newline meeting a result that is still stalled on the output, which holds the
// input register until that result transfers.
module uart_motor_command_decoder_top #(
  parameter int unsigned LINE_LENGTH = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [umcd_pkg::CHAR_W-1:0] in_rx_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_command,
  output logic                        out_motor_a_fwd,
  output logic                        out_motor_a_rev,
  output logic                        out_motor_b_fwd,
  output logic                        out_motor_b_rev,
  output logic [umcd_pkg::DUTY_W-1:0] out_duty_a,
  output logic [umcd_pkg::DUTY_W-1:0] out_duty_b
);
  import umcd_pkg::*;

  localparam int unsigned POS_W = $clog2(LINE_LENGTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LENGTH - 1);

  // input register
  logic              in_valid_r, in_valid_nxt;
  logic [CHAR_W-1:0] in_byte_r;

  // line state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CHAR_W-1:0]  head_r [HEAD_COUNT];
  logic [CHAR_W-1:0]  head_nxt [HEAD_COUNT];
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  phase_t             phase_r, phase_nxt;

  // motor state, also the result payload
  logic [3:0]        pins_r, pins_nxt;
  logic [DUTY_W-1:0] duty_one_r, duty_one_nxt;
  logic [DUTY_W-1:0] duty_two_r, duty_two_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  cmd_t cmd_r, cmd_nxt;

  logic               in_take;
  logic               proc_go;
  logic               is_nl;
  logic               line_open;
  logic               is_digit;
  logic               is_blank;
  logic [ACC_W-1:0]   acc;
  logic [SPEED_W-1:0] acc_sat;
  logic [DUTY_W-1:0]  duty_speed;
  logic               m_ileri, m_geri, m_sag, m_sol, m_dur, m_hiz;

  // a newline needs the result register free or draining this cycle
  assign is_nl   = (in_byte_r == NEWLINE_CODE);
  assign proc_go = in_valid_r && (!is_nl || !out_valid_r || !out_stall);

  // input register moves on whenever it is empty or being consumed
  assign in_stall = in_valid_r && !proc_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (proc_go) begin
      in_valid_nxt = 1'b0;
    end
  end

  // character classes
  assign is_digit  = (in_byte_r >= DIGIT_ZERO) && (in_byte_r <= DIGIT_NINE);
  assign is_blank  = (in_byte_r == SPACE_CODE) ||
                     ((in_byte_r >= TAB_CODE) && (in_byte_r <= CR_CODE));
  assign line_open = (pos_r < POS_LAST);

  // decimal accumulate with saturation, digit value is the low nibble
  assign acc     = ACC_W'(speed_r) * ACC_W'(10) + ACC_W'(in_byte_r[3:0]);
  assign acc_sat = (acc > ACC_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : acc[SPEED_W-1:0];

  assign duty_speed = DUTY_W'(speed_r) * DUTY_W'(DUTY_SCALE);

  // prefix match; unreceived head characters are zero so short lines never match
  assign m_ileri = (head_r[0] == "i") && (head_r[1] == "l") && (head_r[2] == "e") &&
                   (head_r[3] == "r") && (head_r[4] == "i");
  assign m_geri  = (head_r[0] == "g") && (head_r[1] == "e") && (head_r[2] == "r") &&
                   (head_r[3] == "i");
  assign m_sag   = (head_r[0] == "s") && (head_r[1] == "a") && (head_r[2] == "g");
  assign m_sol   = (head_r[0] == "s") && (head_r[1] == "o") && (head_r[2] == "l");
  assign m_dur   = (head_r[0] == "d") && (head_r[1] == "u") && (head_r[2] == "r");
  assign m_hiz   = (head_r[0] == "h") && (head_r[1] == "i") && (head_r[2] == "z");

  always_comb begin
    pos_nxt      = pos_r;
    head_nxt     = head_r;
    speed_nxt    = speed_r;
    phase_nxt    = phase_r;
    pins_nxt     = pins_r;
    duty_one_nxt = duty_one_r;
    duty_two_nxt = duty_two_r;
    cmd_nxt      = cmd_r;

    if (proc_go && !is_nl) begin
      // ordinary character: store head, feed the number parser, advance
      if (line_open) begin
        for (int i = 0; i < HEAD_COUNT; i++) begin
          if (pos_r == POS_W'(i)) begin
            head_nxt[i] = in_byte_r;
          end
        end
        if (pos_r >= POS_W'(NUMBER_START)) begin
          case (phase_r)
            PH_SKIP: begin
              if (is_digit) begin
                speed_nxt = acc_sat;
                phase_nxt = PH_DIGITS;
              end else if (!is_blank) begin
                // sign or other leading character gives zero
                speed_nxt = '0;
                phase_nxt = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                speed_nxt = acc_sat;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_DONE: begin
              phase_nxt = PH_DONE;
            end
            default: begin
              phase_nxt = PH_DONE;
            end
          endcase
        end
        pos_nxt = pos_r + POS_W'(1);
      end
    end else if (proc_go) begin
      // newline: decode, update motor state, clear the line
      cmd_nxt = CMD_UNKNOWN;
      if (m_ileri) begin
        cmd_nxt  = CMD_FORWARD;
        pins_nxt = PINS_FORWARD;
      end else if (m_geri) begin
        cmd_nxt  = CMD_BACK;
        pins_nxt = PINS_BACK;
      end else if (m_sag) begin
        cmd_nxt      = CMD_RIGHT;
        pins_nxt     = PINS_FORWARD;
        duty_one_nxt = duty_one_r >> 1;
      end else if (m_sol) begin
        cmd_nxt      = CMD_LEFT;
        pins_nxt     = PINS_FORWARD;
        duty_two_nxt = duty_two_r >> 1;
      end else if (m_dur) begin
        cmd_nxt  = CMD_STOP;
        pins_nxt = PINS_OFF;
      end else if (m_hiz) begin
        cmd_nxt      = CMD_SPEED;
        duty_one_nxt = duty_speed;
        duty_two_nxt = duty_speed;
      end
      pos_nxt   = '0;
      speed_nxt = '0;
      phase_nxt = PH_SKIP;
      for (int i = 0; i < HEAD_COUNT; i++) begin
        head_nxt[i] = '0;
      end
    end
  end

  // result register fills on a decoded newline, empties on an output transfer
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (proc_go && is_nl) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      speed_r     <= '0;
      phase_r     <= PH_SKIP;
      pins_r      <= PINS_OFF;
      duty_one_r  <= '0;
      duty_two_r  <= '0;
      cmd_r       <= CMD_UNKNOWN;
      for (int i = 0; i < HEAD_COUNT; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      speed_r     <= speed_nxt;
      phase_r     <= phase_nxt;
      pins_r      <= pins_nxt;
      duty_one_r  <= duty_one_nxt;
      duty_two_r  <= duty_two_nxt;
      cmd_r       <= cmd_nxt;
      head_r      <= head_nxt;
    end
  end

  // input byte register, payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // motor state only changes on a newline, which waits for the result slot,
  // so it doubles as the result payload
  assign out_valid       = out_valid_r;
  assign out_command     = cmd_r;
  assign out_motor_a_fwd = pins_r[0];
  assign out_motor_a_rev = pins_r[1];
  assign out_motor_b_fwd = pins_r[2];
  assign out_motor_b_rev = pins_r[3];
  assign out_duty_a      = duty_one_r;
  assign out_duty_b      = duty_two_r;

  // a decoded newline always restarts the line
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && is_nl) |=> (pos_r == '0) && (phase_r == PH_SKIP) && (speed_r == '0))
    else $error("line state not cleared after newline");

  // a new result only appears after a decoded newline
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(proc_go && is_nl))
    else $error("result raised without a newline");

  // a speed result always carries equal duties
  a_speed_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cmd_r == CMD_SPEED)) |-> (duty_one_r == duty_two_r))
    else $error("speed result with unequal duties");

  // a waiting result is never overwritten by another newline
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(proc_go && is_nl))
    else $error("newline decoded over a stalled result");

endmodule
